@@ design/gdwf_pkg.sv @@
// ============================================================================
// gdwf_pkg - shared constants and types for the gradient descent window filter
// Field widths, register indexes, reset values and the status bundles passed
// between the divider, the cost sweep and the top-level controller.
// ============================================================================
`default_nettype none

package gdwf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int CHANGE_W   = 25;
    localparam int DIFF_W     = 25;
    localparam int MAG_W      = 24;
    localparam int STEPS_W    = 8;
    localparam int LEN_W      = 5;
    localparam int COST_W     = 40;
    localparam int AD_W       = 20;
    localparam int POINT_W    = 28;
    localparam int TRIAL_W    = STEPS_W + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DESCENT_STEPS = CFG_INDEX_W'(1);

    localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RESET = LEN_W'(5);
    localparam logic [STEPS_W-1:0] DESCENT_STEPS_RESET = STEPS_W'(5);

    localparam int DEFAULT_WINDOW_DEPTH = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Divider result: quotient and remainder of the step magnitude
    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   quot;
        logic [STEPS_W-1:0] rem;
    } div_rsp_t;

    // Cost sweep result
    typedef struct packed {
        logic              done;
        logic [COST_W-1:0] cost;
    } cost_rsp_t;

endpackage

`default_nettype wire

@@ design/gradient_descent_window_filter.sv @@
// ============================================================================
// gradient_descent_window_filter - sample filter by gradient descent on a window
// Stores each sample in a circular window and walks the output toward the
// point of least squared error over the active window entries.
// ============================================================================
// Usage:
//   Input channel: in_valid / in_stall with the signed 16-bit sample. A beat
//   is taken when in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with filtered and change; one
//   result beat per input beat, in order.
//   Configuration: cfg_we writes cfg_data to the register at cfg_index
//   (0 window_length, 1 descent_steps); write only while the block is idle.
//   Timing: one sample at a time. Each sample runs the step divider, then T
//   descent trials, T from 1 to descent_steps + 1. Each trial is a cost sweep
//   that reads the L active window entries, L the active window length, one
//   entry per cycle from the window memory.
//   The next sample is taken while the last result waits in the output
//   register; a new result waits only if that register is still stalled.
//   Reset: window reads as zero, output, cost and window pointer are zero,
//   window_length and descent_steps are 5. No clearing pass is needed.
// ============================================================================
`default_nettype none

module gradient_descent_window_filter #(
    parameter int WINDOW_DEPTH = gdwf_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [gdwf_pkg::SAMPLE_W-1:0]       sample,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [gdwf_pkg::OUT_W-1:0]          filtered,
    output logic      [gdwf_pkg::CHANGE_W-1:0]       change,
    input  wire logic                                cfg_we,
    input  wire logic [gdwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gdwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int POINT_W = gdwf_pkg::POINT_W;
    localparam int OUT_W   = gdwf_pkg::OUT_W;
    localparam int DIFF_W  = gdwf_pkg::DIFF_W;
    localparam int MAG_W   = gdwf_pkg::MAG_W;
    localparam int STEPS_W = gdwf_pkg::STEPS_W;
    localparam int TRIAL_W = gdwf_pkg::TRIAL_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_START  = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;

    logic [gdwf_pkg::LEN_W-1:0]      window_length_reg;
    logic [STEPS_W-1:0]              descent_steps_reg;
    logic [AW-1:0]                   wp_reg;
    logic [OUT_W-1:0]                current_output_reg;
    logic [gdwf_pkg::COST_W-1:0]     last_cost_reg;
    logic [gdwf_pkg::COST_W-1:0]     last_cost_next;
    logic [POINT_W-1:0]              point_reg;
    logic [POINT_W-1:0]              point_next;
    logic                            sn_neg_reg;
    logic                            pn_neg_reg;
    logic                            pn_neg_next;
    logic                            rising_reg;
    logic                            rising_next;
    logic                            falls2_reg;
    logic                            falls2_next;
    logic [TRIAL_W-1:0]              trials_reg;
    logic [TRIAL_W-1:0]              trials_next;
    logic                            out_valid_reg;
    logic [OUT_W-1:0]                filtered_reg;
    logic [gdwf_pkg::CHANGE_W-1:0]   change_reg;

    logic                            in_accept;
    logic                            out_free;
    logic [CNT_W-1:0]                len_eff;
    logic [STEPS_W-1:0]              steps_eff;
    logic [CNT_W-1:0]                p_inc;
    logic [AW-1:0]                   p_new;
    logic [DIFF_W-1:0]               diff;
    logic [DIFF_W-1:0]               diff_abs;
    logic [MAG_W-1:0]                step_mag;
    logic                            rise;
    logic                            stop;
    logic                            move_neg;
    logic                            rem_nz;
    logic [POINT_W-1:0]              qa_ext;
    logic [POINT_W-1:0]              q;
    logic [POINT_W-1:0]              t;
    logic                            sat_hi;
    logic                            sat_lo;
    logic [OUT_W-1:0]                result;
    logic [gdwf_pkg::CHANGE_W-1:0]   result_change;

    logic                            mem_rd_en;
    logic [AW-1:0]                   mem_rd_addr;
    logic [gdwf_pkg::SAMPLE_W-1:0]   mem_rd_data;
    gdwf_pkg::div_rsp_t              div_rsp;
    gdwf_pkg::cost_rsp_t             cost_rsp;

    // Handshake
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;

    // Effective register values
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (32'(window_length_reg) > WINDOW_DEPTH)
        begin
            len_eff = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_eff = CNT_W'(window_length_reg);
        end
        steps_eff = (descent_steps_reg == '0) ? STEPS_W'(1) : descent_steps_reg;
    end

    // Window pointer advance and step magnitude for the new sample
    always_comb
    begin
        p_inc    = CNT_W'(wp_reg) + 1'b1;
        p_new    = (p_inc >= len_eff) ? '0 : p_inc[AW-1:0];
        diff     = {{(DIFF_W - gdwf_pkg::SAMPLE_W){sample[gdwf_pkg::SAMPLE_W-1]}}, sample}
                 - {{(DIFF_W - OUT_W){current_output_reg[OUT_W-1]}}, current_output_reg};
        diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        if (diff_abs[MAG_W-1:0] < MAG_W'(steps_eff))
        begin
            step_mag = (diff_abs[MAG_W-1:0] < MAG_W'(2)) ? '0 : MAG_W'(steps_eff);
        end
        else
        begin
            step_mag = diff_abs[MAG_W-1:0];
        end
    end

    // Evaluate one trial and move the candidate
    always_comb
    begin
        rise           = cost_rsp.cost > last_cost_reg;
        rising_next    = rise;
        pn_neg_next    = pn_neg_reg ^ rise;
        falls2_next    = falls2_reg || (!rise && (steps_eff > STEPS_W'(1)));
        last_cost_next = cost_rsp.cost;
        trials_next    = trials_reg + 1'b1;
        stop           = (rise && !rising_reg) || (trials_next > TRIAL_W'(steps_eff))
                         || falls2_next;
        move_neg       = pn_neg_next ^ sn_neg_reg;
        rem_nz         = div_rsp.rem != '0;
        qa_ext         = POINT_W'(div_rsp.quot);
        // floor quotient of the signed move: -Q when exact, else -Q-1
        q              = move_neg ? (~qa_ext + POINT_W'(!rem_nz)) : qa_ext;
        t              = point_reg + q;
        // truncate toward zero: a negative inexact result rounds up
        point_next     = t + POINT_W'(t[POINT_W-1] && rem_nz);
    end

    // Saturate the end point and form the change
    always_comb
    begin
        sat_hi = !point_reg[POINT_W-1] && (|point_reg[POINT_W-2:OUT_W-1]);
        sat_lo = point_reg[POINT_W-1] && !(&point_reg[POINT_W-2:OUT_W-1]);
        if (sat_hi)
        begin
            result = {1'b0, {(OUT_W - 1){1'b1}}};
        end
        else if (sat_lo)
        begin
            result = {1'b1, {(OUT_W - 1){1'b0}}};
        end
        else
        begin
            result = point_reg[OUT_W-1:0];
        end
        result_change = {result[OUT_W-1], result}
                      - {current_output_reg[OUT_W-1], current_output_reg};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (cost_rsp.done)
                begin
                    state_next = stop ? S_FINISH : S_START;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            window_length_reg  <= gdwf_pkg::WINDOW_LENGTH_RESET;
            descent_steps_reg  <= gdwf_pkg::DESCENT_STEPS_RESET;
            wp_reg             <= '0;
            current_output_reg <= '0;
            last_cost_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes; unknown indexes drop
            if (cfg_we)
            begin
                case (cfg_index)
                    gdwf_pkg::REG_WINDOW_LENGTH:
                    begin
                        window_length_reg <= cfg_data[gdwf_pkg::LEN_W-1:0];
                    end
                    gdwf_pkg::REG_DESCENT_STEPS:
                    begin
                        descent_steps_reg <= cfg_data[STEPS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
            begin
                wp_reg <= p_new;
            end

            if (state_reg == S_SWEEP && cost_rsp.done)
            begin
                last_cost_reg <= last_cost_next;
            end

            // Hold the result beat until taken; load the next when free
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg      <= 1'b1;
                current_output_reg <= result;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk registers and output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sn_neg_reg <= diff[DIFF_W-1];
            point_reg  <= {{(POINT_W - OUT_W){current_output_reg[OUT_W-1]}},
                           current_output_reg};
            pn_neg_reg <= 1'b0;
            rising_reg <= 1'b1;
            falls2_reg <= 1'b0;
            trials_reg <= '0;
        end
        else if (state_reg == S_SWEEP && cost_rsp.done)
        begin
            point_reg  <= point_next;
            pn_neg_reg <= pn_neg_next;
            rising_reg <= rising_next;
            falls2_reg <= falls2_next;
            trials_reg <= trials_next;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            filtered_reg <= result;
            change_reg   <= result_change;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign change    = change_reg;

    // Window memory: written on accept, read by the cost sweep
    gdwf_win_mem #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_win_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_addr (p_new),
        .wr_data (sample),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Step divider
    gdwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .dividend (step_mag),
        .divisor  (steps_eff),
        .rsp      (div_rsp)
    );

    // Cost sweep
    gdwf_cost #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_cost (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_START),
        .len     (len_eff),
        .point   (point_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .rsp     (cost_rsp)
    );

    // Checks
    a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_DIV)
        else $error("accepted sample did not start the divider");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_cost_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cost_rsp.done |-> state_reg == S_SWEEP)
        else $error("cost sweep finished outside a trial");

    a_trial_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_START |-> trials_reg <= TRIAL_W'(steps_eff))
        else $error("descent trial count beyond its limit");

endmodule

`default_nettype wire

@@ design/gdwf_win_mem.sv @@
// ============================================================================
// gdwf_win_mem - sample window memory
// One write port and one read port with registered read data. Per-entry valid
// bits make entries that were never written read as zero after reset.
// ============================================================================
`default_nettype none

module gdwf_win_mem #(
    parameter int WINDOW_DEPTH = gdwf_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(WINDOW_DEPTH)-1:0]   wr_addr,
    input  wire logic [gdwf_pkg::SAMPLE_W-1:0]     wr_data,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(WINDOW_DEPTH)-1:0]   rd_addr,
    output logic      [gdwf_pkg::SAMPLE_W-1:0]     rd_data
);

    logic [gdwf_pkg::SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]       valid_reg;
    logic [gdwf_pkg::SAMPLE_W-1:0] rd_word_reg;
    logic                          rd_valid_reg;

    // Write the array and register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= window_mem[rd_addr];
        end
    end

    // Track written entries and register the valid bit of the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

@@ design/gdwf_div.sv @@
// ============================================================================
// gdwf_div - restoring divider for the descent step
// Divides the step magnitude by the step count, one quotient bit per cycle.
// Quotient and remainder hold until the next start.
// ============================================================================
`default_nettype none

module gdwf_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [gdwf_pkg::MAG_W-1:0]     dividend,
    input  wire logic [gdwf_pkg::STEPS_W-1:0]   divisor,
    output gdwf_pkg::div_rsp_t                  rsp
);

    localparam int CNT_W = $clog2(gdwf_pkg::MAG_W);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [gdwf_pkg::MAG_W-1:0]     quot_reg;
    logic [gdwf_pkg::STEPS_W-1:0]   rem_reg;
    logic [gdwf_pkg::STEPS_W-1:0]   divisor_reg;

    logic [gdwf_pkg::STEPS_W:0]     trial;
    logic                           fits;
    logic [gdwf_pkg::STEPS_W:0]     trial_sub;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial     = {rem_reg, quot_reg[gdwf_pkg::MAG_W-1]};
        fits      = trial >= {1'b0, divisor_reg};
        trial_sub = trial - {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(gdwf_pkg::MAG_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[gdwf_pkg::MAG_W-2:0], fits};
            rem_reg  <= fits ? trial_sub[gdwf_pkg::STEPS_W-1:0]
                             : trial[gdwf_pkg::STEPS_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

@@ design/gdwf_cost.sv @@
// ============================================================================
// gdwf_cost - windowed squared-error sweep
// Reads the active window entries one per cycle from the window memory and
// sums the squared distance to the candidate point, saturating at the cost
// limit. Stages: read, difference, square, accumulate.
// ============================================================================
`default_nettype none

module gdwf_cost #(
    parameter int WINDOW_DEPTH = gdwf_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]      len,
    input  wire logic [gdwf_pkg::POINT_W-1:0]           point,
    output logic                                        rd_en,
    output logic      [$clog2(WINDOW_DEPTH)-1:0]        rd_addr,
    input  wire logic [gdwf_pkg::SAMPLE_W-1:0]          rd_data,
    output gdwf_pkg::cost_rsp_t                         rsp
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int D_W   = gdwf_pkg::POINT_W + 1;

    logic                             busy_reg;
    logic [CNT_W-1:0]                 idx_reg;
    logic                             last;

    logic                             v1_reg;
    logic                             l1_reg;
    logic                             v2_reg;
    logic                             l2_reg;
    logic                             big2_reg;
    logic [gdwf_pkg::AD_W-1:0]        ad2_reg;
    logic                             v3_reg;
    logic                             l3_reg;
    logic                             big3_reg;
    logic [gdwf_pkg::COST_W-1:0]      prod3_reg;
    logic [gdwf_pkg::COST_W-1:0]      acc_reg;
    logic                             done_reg;

    logic [D_W-1:0]                   diff;
    logic [D_W-1:0]                   mag;
    logic                             big;
    logic [gdwf_pkg::COST_W:0]        sum;

    // Issue one read per cycle
    assign last    = idx_reg == (len - 1'b1);
    assign rd_en   = busy_reg;
    assign rd_addr = idx_reg[AW-1:0];

    // Distance of the entry to the candidate
    always_comb
    begin
        diff = {{(D_W - gdwf_pkg::SAMPLE_W){rd_data[gdwf_pkg::SAMPLE_W-1]}}, rd_data}
             - {point[gdwf_pkg::POINT_W-1], point};
        mag  = diff[D_W-1] ? (~diff + 1'b1) : diff;
        big  = |mag[D_W-1:gdwf_pkg::AD_W];
        sum  = {1'b0, acc_reg} + {1'b0, prod3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            v1_reg   <= 1'b0;
            l1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            l2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            l3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Advance the read index
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            // Move the stage markers along
            v1_reg   <= rd_en;
            l1_reg   <= rd_en & last;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            v3_reg   <= v2_reg;
            l3_reg   <= l2_reg;
            done_reg <= v3_reg & l3_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        big2_reg  <= big;
        ad2_reg   <= mag[gdwf_pkg::AD_W-1:0];
        big3_reg  <= big2_reg;
        prod3_reg <= ad2_reg * ad2_reg;
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= (big3_reg || sum[gdwf_pkg::COST_W]) ? gdwf_pkg::COST_MAX
                                                           : sum[gdwf_pkg::COST_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.cost = acc_reg;

endmodule

`default_nettype wire
